>>> design/flipper_efficiency_with_error_top_assert.svh
// Assertion macros for the flipper efficiency block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FLIPPER_EFFICIENCY_WITH_ERROR_TOP_ASSERT_SVH
`define FLIPPER_EFFICIENCY_WITH_ERROR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FEWE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FEWE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fewe_pkg.sv
// Shared types and constants for the flipper efficiency block.
// Used by the pipelined divider and the top level; depends on nothing.
package fewe_pkg;

    localparam int FIELD_W      = 16;
    localparam int OUT_W        = 24;
    localparam int QUO_W        = OUT_W + 1;
    localparam int IN_BITS_DEF  = 16;
    localparam int OUT_FRAC_DEF = 20;

    localparam logic [OUT_W-1:0] EFF_POS_MAX = 24'h7FFFFF;
    localparam logic [OUT_W-1:0] EFF_NEG_MAG = 24'h800000;
    localparam logic [OUT_W-1:0] ERR_MAX     = 24'hFFFFFF;

    typedef struct packed {
        logic [FIELD_W-1:0] t_on_on;
        logic [FIELD_W-1:0] t_on_off;
        logic [FIELD_W-1:0] t_off_on;
        logic [FIELD_W-1:0] t_off_off;
        logic [FIELD_W-1:0] e_on_on;
        logic [FIELD_W-1:0] e_on_off;
        logic [FIELD_W-1:0] e_off_on;
        logic [FIELD_W-1:0] e_off_off;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] efficiency;
        logic [OUT_W-1:0]        efficiency_error;
        logic                    zero_denominator;
        logic                    saturated;
    } t_out;

endpackage

>>> design/fewe_div_pipe.sv
// Pipelined restoring divider: floor(num * 2^SHIFT / den), one quotient bit per stage.
// Flags quotients of 2^Q_W or more. Depends on fewe_pkg.
module fewe_div_pipe import fewe_pkg::*; #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 33,
    parameter int SHIFT = OUT_FRAC_DEF + 1,
    parameter int Q_W   = QUO_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_ovf
);

    localparam int N_W   = NUM_W + SHIFT;
    localparam int HI_W  = N_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [N_W-1:0]   w_n;
    logic [HI_W-1:0]  w_hi;
    logic             w_ovf;

    logic [DEN_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_low [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W+1];
    logic             r_ovf [Q_W+1];

    assign w_n   = {i_num, {SHIFT{1'b0}}};
    assign w_hi  = w_n[N_W-1:Q_W];
    assign w_ovf = CMP_W'(w_hi) >= CMP_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_ovf ? '0 : DEN_W'(w_hi);
            r_den[0] <= i_den;
            r_low[0] <= w_n[Q_W-1:0];
            r_quo[0] <= '0;
            r_ovf[0] <= w_ovf;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        logic [DEN_W:0] w_t;
        logic [DEN_W:0] w_d;
        logic           w_ge;

        assign w_t  = {r_rem[k-1], r_low[k-1][Q_W-1]};
        assign w_d  = {1'b0, r_den[k-1]};
        assign w_ge = w_t >= w_d;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {r_quo[k-1][Q_W-2:0], w_ge};
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < Q_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? DEN_W'(w_t - w_d) : DEN_W'(w_t);
                    r_den[k] <= r_den[k-1];
                    r_low[k] <= r_low[k-1] << 1;
                end
            end
        end
    end

    assign o_quo = r_quo[Q_W];
    assign o_ovf = r_ovf[Q_W];

endmodule

>>> design/flipper_efficiency_with_error_top.sv
// Flipper efficiency with propagated error, one wavelength bin per item.
// The pipeline holds three arithmetic stages, the OUT_W+2 stage dividers, three rounding
// and squaring stages, and an OUT_W+1 stage root.
// Throughput is one item per cycle; a stalled output freezes every stage in place.
// Synchronous active-low reset clears all valid bits and the mode register.
`include "flipper_efficiency_with_error_top_assert.svh"

module flipper_efficiency_with_error_top import fewe_pkg::*; #(
    parameter int IN_BITS       = IN_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data
);

    localparam int IW       = IN_BITS;
    localparam int S_W      = IW + 1;
    localparam int P_W      = 2 * IW;
    localparam int ST_W     = 2 * IW + 1;
    localparam int SS_W     = 2 * IW + 2;
    localparam int NA_W     = 2 * IW + 1;
    localparam int NUM_W    = 3 * IW + 1;
    localparam int DEN_W    = 3 * IW + 2;
    localparam int SHIFT    = OUT_FRAC_BITS + 1;
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int SQR_W    = 2 * OUT_W;
    localparam int SQ_STEPS = OUT_W + 1;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int REM_W    = ROOT_W + 2;
    localparam int RR_W     = ROOT_W + 1;

    typedef struct packed {
        logic             over;
        logic [OUT_W-1:0] val;
    } t_rnd;

    typedef struct packed {
        logic [OUT_W-1:0] eff;
        logic             sat;
        logic             esat;
        logic             zero;
    } t_side;

    function automatic t_rnd f_round(input logic [QUO_W-1:0] quo, input logic ovf,
                                     input logic [OUT_W-1:0] cap);
        logic [QUO_W-1:0] lim;
        logic [QUO_W:0]   inc;
        t_rnd             res;
        lim      = {cap, 1'b1};
        inc      = {1'b0, quo} + {{QUO_W{1'b0}}, 1'b1};
        res.over = ovf || (quo >= lim);
        res.val  = res.over ? cap : inc[OUT_W:1];
        return res;
    endfunction

    logic w_en;
    logic r_mode;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // Stage 1: select cross terms, sums and differences.
    logic [IW-1:0] w_a, w_b, w_c, w_d, w_ea, w_eb, w_ec, w_ed;
    logic [IW-1:0] w_x, w_y, w_ex, w_ey, w_tmag, w_dab;
    logic [S_W-1:0] w_s, w_sum;
    logic w_tneg;

    assign w_a    = IW'(i_data.t_on_on);
    assign w_b    = IW'(i_data.t_on_off);
    assign w_c    = IW'(i_data.t_off_on);
    assign w_d    = IW'(i_data.t_off_off);
    assign w_ea   = IW'(i_data.e_on_on);
    assign w_eb   = IW'(i_data.e_on_off);
    assign w_ec   = IW'(i_data.e_off_on);
    assign w_ed   = IW'(i_data.e_off_off);
    assign w_x    = r_mode ? w_c : w_b;
    assign w_y    = r_mode ? w_b : w_c;
    assign w_ex   = r_mode ? w_ec : w_eb;
    assign w_ey   = r_mode ? w_eb : w_ec;
    assign w_s    = {1'b0, w_a} + {1'b0, w_x};
    assign w_sum  = {1'b0, w_d} + {1'b0, w_y};
    assign w_tneg = w_d < w_y;
    assign w_tmag = w_tneg ? (w_y - w_d) : (w_d - w_y);
    assign w_dab  = (w_a >= w_x) ? (w_a - w_x) : (w_x - w_a);

    logic [IW-1:0]  r1_a, r1_x, r1_y, r1_d, r1_ea, r1_ex, r1_ey, r1_ed, r1_tmag, r1_dab;
    logic [S_W-1:0] r1_s, r1_sum;
    logic r1_tneg, r1_zero, r1_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a    <= w_a;
            r1_x    <= w_x;
            r1_y    <= w_y;
            r1_d    <= w_d;
            r1_ea   <= w_ea;
            r1_ex   <= w_ex;
            r1_ey   <= w_ey;
            r1_ed   <= w_ed;
            r1_tmag <= w_tmag;
            r1_dab  <= w_dab;
            r1_s    <= w_s;
            r1_sum  <= w_sum;
            r1_tneg <= w_tneg;
            r1_zero <= (w_s == '0) || (w_tmag == '0);
        end
    end

    // Stage 2: first products.
    logic [P_W-1:0]  r2_p, r2_q, r2_ny, r2_nd;
    logic [ST_W-1:0] r2_st;
    logic [SS_W-1:0] r2_ss;
    logic [NA_W-1:0] r2_na, r2_nx;
    logic [IW-1:0]   r2_ea, r2_ex, r2_ey, r2_ed, r2_tmag;
    logic r2_tneg, r2_zero, r2_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_p    <= P_W'(r1_a) * P_W'(r1_d);
            r2_q    <= P_W'(r1_x) * P_W'(r1_y);
            r2_st   <= ST_W'(r1_s) * ST_W'(r1_tmag);
            r2_ss   <= SS_W'(r1_s) * SS_W'(r1_s);
            r2_na   <= NA_W'(r1_x) * NA_W'(r1_sum);
            r2_nx   <= NA_W'(r1_a) * NA_W'(r1_sum);
            r2_ny   <= P_W'(r1_d) * P_W'(r1_dab);
            r2_nd   <= P_W'(r1_y) * P_W'(r1_dab);
            r2_ea   <= r1_ea;
            r2_ex   <= r1_ex;
            r2_ey   <= r1_ey;
            r2_ed   <= r1_ed;
            r2_tmag <= r1_tmag;
            r2_tneg <= r1_tneg;
            r2_zero <= r1_zero;
        end
    end

    // Stage 3: numerator sign and magnitude, second products.
    logic w_nneg;
    logic [P_W-1:0] w_nmag;

    assign w_nneg = r2_p < r2_q;
    assign w_nmag = w_nneg ? (r2_q - r2_p) : (r2_p - r2_q);

    logic [P_W-1:0]   r3_nmag;
    logic [ST_W-1:0]  r3_st;
    logic [DEN_W-1:0] r3_den1, r3_den0;
    logic [NUM_W-1:0] r3_na, r3_nx, r3_ny, r3_nd;
    logic r3_neg, r3_zero, r3_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_nmag <= w_nmag;
            r3_neg  <= (w_nneg != r2_tneg) && (w_nmag != '0);
            r3_st   <= r2_st;
            r3_den1 <= DEN_W'(r2_ss) * DEN_W'(r2_tmag);
            r3_den0 <= DEN_W'(r2_st) * DEN_W'(r2_tmag);
            r3_na   <= NUM_W'(r2_na) * NUM_W'(r2_ea);
            r3_nx   <= NUM_W'(r2_nx) * NUM_W'(r2_ex);
            r3_ny   <= NUM_W'(r2_ny) * NUM_W'(r2_ey);
            r3_nd   <= NUM_W'(r2_nd) * NUM_W'(r2_ed);
            r3_zero <= r2_zero;
        end
    end

    // Dividers.
    logic [QUO_W-1:0] w_qe, w_qa, w_qx, w_qy, w_qd;
    logic w_oe, w_oa, w_ox, w_oy, w_od;

    fewe_div_pipe #(.NUM_W(P_W), .DEN_W(ST_W), .SHIFT(SHIFT), .Q_W(QUO_W)) u_div_eff (
        .i_clk(i_clk), .i_en(w_en), .i_num(r3_nmag), .i_den(r3_st),
        .o_quo(w_qe), .o_ovf(w_oe)
    );
    fewe_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SHIFT(SHIFT), .Q_W(QUO_W)) u_div_a (
        .i_clk(i_clk), .i_en(w_en), .i_num(r3_na), .i_den(r3_den1),
        .o_quo(w_qa), .o_ovf(w_oa)
    );
    fewe_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SHIFT(SHIFT), .Q_W(QUO_W)) u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_num(r3_nx), .i_den(r3_den1),
        .o_quo(w_qx), .o_ovf(w_ox)
    );
    fewe_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SHIFT(SHIFT), .Q_W(QUO_W)) u_div_y (
        .i_clk(i_clk), .i_en(w_en), .i_num(r3_ny), .i_den(r3_den0),
        .o_quo(w_qy), .o_ovf(w_oy)
    );
    fewe_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SHIFT(SHIFT), .Q_W(QUO_W)) u_div_d (
        .i_clk(i_clk), .i_en(w_en), .i_num(r3_nd), .i_den(r3_den0),
        .o_quo(w_qd), .o_ovf(w_od)
    );

    logic [DIV_LAT-1:0] r_vdiv, r_negd, r_zerod;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_negd  <= {r_negd[DIV_LAT-2:0], r3_neg};
            r_zerod <= {r_zerod[DIV_LAT-2:0], r3_zero};
        end
    end

    // Stage 4: rounding and clipping of all quotients.
    logic w_neg;
    t_rnd w_re, w_ra, w_rx, w_ry, w_rd;

    assign w_neg = r_negd[DIV_LAT-1];
    assign w_re  = f_round(w_qe, w_oe, w_neg ? EFF_NEG_MAG : EFF_POS_MAX);
    assign w_ra  = f_round(w_qa, w_oa, ERR_MAX);
    assign w_rx  = f_round(w_qx, w_ox, ERR_MAX);
    assign w_ry  = f_round(w_qy, w_oy, ERR_MAX);
    assign w_rd  = f_round(w_qd, w_od, ERR_MAX);

    logic [OUT_W-1:0] r4_ra, r4_rx, r4_ry, r4_rd;
    t_side r4_sd, r5_sd, r6_sd;
    logic r4_v, r5_v, r6_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ra      <= w_ra.val;
            r4_rx      <= w_rx.val;
            r4_ry      <= w_ry.val;
            r4_rd      <= w_rd.val;
            r4_sd.eff  <= w_neg ? (OUT_W'(0) - w_re.val) : w_re.val;
            r4_sd.sat  <= w_re.over;
            r4_sd.esat <= w_ra.over || w_rx.over || w_ry.over || w_rd.over;
            r4_sd.zero <= r_zerod[DIV_LAT-1];
        end
    end

    // Stage 5: squares. Stage 6: sum of squares.
    logic [SQR_W-1:0] r5_sa, r5_sx, r5_sy, r5_sd2;
    logic [RAD_W-1:0] r6_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_sa  <= SQR_W'(r4_ra) * SQR_W'(r4_ra);
            r5_sx  <= SQR_W'(r4_rx) * SQR_W'(r4_rx);
            r5_sy  <= SQR_W'(r4_ry) * SQR_W'(r4_ry);
            r5_sd2 <= SQR_W'(r4_rd) * SQR_W'(r4_rd);
            r5_sd  <= r4_sd;
            r6_sum <= RAD_W'(r5_sa) + RAD_W'(r5_sx) + RAD_W'(r5_sy) + RAD_W'(r5_sd2);
            r6_sd  <= r5_sd;
        end
    end

    // Square root, one result bit per stage.
    logic [REM_W-1:0]  r_sq_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] r_sq_root [SQ_STEPS];
    logic [RAD_W-1:0]  r_sq_rad  [SQ_STEPS-1];
    t_side             r_sq_sd   [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_vsq;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [RAD_W-1:0]  w_rad_in;
        t_side             w_sd_in;
        logic [REM_W+1:0]  w_t, w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = r6_sum;
            assign w_sd_in   = r6_sd;
        end else begin : g_next
            assign w_rem_in  = r_sq_rem[k-1];
            assign w_root_in = r_sq_root[k-1];
            assign w_rad_in  = r_sq_rad[k-1];
            assign w_sd_in   = r_sq_sd[k-1];
        end

        assign w_t     = {w_rem_in, w_rad_in[RAD_W-1 -: 2]};
        assign w_trial = (REM_W+2)'({w_root_in, 2'b01});
        assign w_ge    = w_t >= w_trial;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k]  <= w_ge ? REM_W'(w_t - w_trial) : REM_W'(w_t);
                r_sq_root[k] <= {w_root_in[ROOT_W-2:0], w_ge};
                r_sq_sd[k]   <= w_sd_in;
            end
        end

        if (k < SQ_STEPS - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sq_rad[k] <= w_rad_in << 2;
                end
            end
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_vdiv  <= '0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r_vsq   <= '0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_vdiv  <= {r_vdiv[DIV_LAT-2:0], r3_v};
            r4_v    <= r_vdiv[DIV_LAT-1];
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r_vsq   <= {r_vsq[SQ_STEPS-2:0], r6_v};
            o_valid <= r_vsq[SQ_STEPS-1];
        end
    end

    // Final rounding of the root and output register.
    t_side             w_fsd;
    logic [ROOT_W-1:0] w_root;
    logic [REM_W-1:0]  w_rem;
    logic [RR_W-1:0]   w_rr;
    logic              w_esat;

    assign w_fsd  = r_sq_sd[SQ_STEPS-1];
    assign w_root = r_sq_root[SQ_STEPS-1];
    assign w_rem  = r_sq_rem[SQ_STEPS-1];
    assign w_rr   = {1'b0, w_root} + {{ROOT_W{1'b0}}, (w_rem > REM_W'(w_root))};
    assign w_esat = w_fsd.esat || (w_rr > RR_W'(ERR_MAX));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_fsd.zero) begin
                o_data.efficiency       <= '0;
                o_data.efficiency_error <= '0;
                o_data.zero_denominator <= 1'b1;
                o_data.saturated        <= 1'b0;
            end else begin
                o_data.efficiency       <= $signed(w_fsd.eff);
                o_data.efficiency_error <= w_esat ? ERR_MAX : w_rr[OUT_W-1:0];
                o_data.zero_denominator <= 1'b0;
                o_data.saturated        <= w_fsd.sat || w_esat;
            end
        end
    end

    `FEWE_ASSERT_IMP(a_zero_den_clears, o_valid && o_data.zero_denominator, o_data.efficiency == '0 && o_data.efficiency_error == '0 && !o_data.saturated, "zero denominator item has nonzero fields")
    `FEWE_ASSERT_IMP(a_sat_at_limit, o_valid && o_data.saturated, $unsigned(o_data.efficiency) == EFF_POS_MAX || $unsigned(o_data.efficiency) == EFF_NEG_MAG || o_data.efficiency_error == ERR_MAX, "saturated item not at a limit")
    `FEWE_ASSERT_NEXT(a_freeze_holds, i_rst_n && o_stall, $stable(r_vsq) && $stable(r_vdiv) && $stable(r4_v), "pipeline moved while stalled")

endmodule
